### rtl/pcs_pkg.sv
// Shared constants, types and state codes of the percentile contrast stretch.
`default_nettype none
package pcs_pkg;

  localparam int unsigned BINS       = 256;
  localparam int unsigned BIN_W      = 8;
  localparam int unsigned CNT_W      = 21;
  localparam int unsigned MAX_PIXELS = 1048576;
  localparam int unsigned PCT_W      = 11;
  localparam int unsigned LIM_W      = 33;
  localparam int unsigned NUM_W      = 24;
  localparam int unsigned DEN_W      = 13;
  localparam int unsigned Q_W        = 8;

  localparam logic [PCT_W-1:0] PCT_RESET = 11'd16;

  // register indexes (decoded from paddr[2])
  localparam logic REG_LOW_PCT  = 1'b0;
  localparam logic REG_HIGH_PCT = 1'b1;

  localparam logic CMD_ACCUM = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_LEVELS = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_ACC_WR = 8'b0000_0010,
    S_MUL    = 8'b0000_0100,
    S_LOW    = 8'b0000_1000,
    S_HIGH   = 8'b0001_0000,
    S_CLEAR  = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

### rtl/pcs_in_if.sv
// Input channel: one pixel beat with its command and frame-end flag.
`default_nettype none
interface pcs_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] pixel;
  logic               last;
  modport source (output valid, cmd, pixel, last, input ready);
  modport sink (input valid, cmd, pixel, last, output ready);
endinterface
`default_nettype wire

### rtl/pcs_out_if.sv
// Output channel: one result beat, either a mapped pixel or new cut levels.
`default_nettype none
interface pcs_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        mapped;
  logic signed [8:0] low_cut;
  logic [8:0]        high_cut;
  logic              zero_span;
  modport source (output valid, kind, mapped, low_cut, high_cut, zero_span, input ready);
  modport sink (input valid, kind, mapped, low_cut, high_cut, zero_span, output ready);
endinterface
`default_nettype wire

### rtl/pcs_hist_mem.sv
// Histogram memory: 256 bins, one write port, one read port with registered data.
`default_nettype none
module pcs_hist_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [pcs_pkg::BIN_W-1:0]   waddr_i,
  input  logic [pcs_pkg::CNT_W-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [pcs_pkg::BIN_W-1:0]   raddr_i,
  output logic [pcs_pkg::CNT_W-1:0]   rdata_o
);
  logic [pcs_pkg::CNT_W-1:0] mem_q [pcs_pkg::BINS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

### rtl/pcs_div.sv
// Restoring divider: saturating 8-bit quotient of two magnitudes, one bit a cycle.
`default_nettype none
module pcs_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcs_pkg::div_req_t req_i,
  output pcs_pkg::div_rsp_t rsp_o
);
  localparam int unsigned SH_W = pcs_pkg::DEN_W + pcs_pkg::Q_W;

  logic [pcs_pkg::NUM_W-1:0] rem_q, rem_d;
  logic [pcs_pkg::NUM_W-1:0] dsh_q, dsh_d;
  logic [pcs_pkg::Q_W-1:0]   quot_q, quot_d;
  logic [3:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      sat_q, sat_d;
  logic                      done_q, done_d;
  logic [SH_W-1:0]           dfull;
  logic                      ge;

  assign dfull = {req_i.den_mag, {pcs_pkg::Q_W{1'b0}}};
  assign ge    = rem_q >= dsh_q;

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sat_d  = sat_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = req_i.num_mag;
      // first trial divisor is the divisor times 128
      dsh_d  = pcs_pkg::NUM_W'({req_i.den_mag, {(pcs_pkg::Q_W-1){1'b0}}});
      quot_d = '0;
      cnt_d  = 4'(pcs_pkg::Q_W);
      busy_d = 1'b1;
      sat_d  = pcs_pkg::NUM_W'(dfull) <= req_i.num_mag;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[pcs_pkg::Q_W-2:0], ge};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    sat_q  <= sat_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = sat_q ? {pcs_pkg::Q_W{1'b1}} : quot_q;
endmodule
`default_nettype wire

### rtl/percentile_contrast_stretch.sv
// Top level of the percentile clipped contrast stretch.
// Usage:
//   in_i carries one pixel beat (cmd, Q12.4 pixel, last). cmd accumulate counts
//   the pixel's clamped integer part into a 256-bin histogram held in one
//   synchronous RAM (read, add one, write back), up to 1048576 pixels a frame.
//   An accumulate beat with last set starts the cut computation: a multiply
//   step, a bin walk up from bin 0 and one down from bin 255, one RAM read a
//   cycle, pipelined, then a clearing sweep of all 256 RAM bins. The levels
//   beat then appears on out_o. A map beat runs through the 8-step restoring
//   divider to the result beat.
//   One beat is worked on at a time; in_i.ready is high whenever the block is
//   idle, even while a finished result waits in the output register. If the
//   receiver stalls, the next result holds in its done state until the
//   output register frees.
//   After reset the histogram RAM is cleared by a sweep of all 256 bins during
//   which no beat is accepted; the cuts are 0 and 255, both percents 16.
//   APB: low_percent at 0x0, high_percent at 0x4; pready is always high.
`default_nettype none
module percentile_contrast_stretch (
  input  logic         clk_i,
  input  logic         rst_ni,
  pcs_in_if.sink       in_i,
  pcs_out_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int unsigned BW = pcs_pkg::BIN_W;
  localparam int unsigned CW = pcs_pkg::CNT_W;
  localparam int unsigned LW = pcs_pkg::LIM_W;

  pcs_pkg::state_e state_q, state_d;

  logic [pcs_pkg::PCT_W-1:0] low_pct_q, high_pct_q;
  logic [CW-1:0]             count_q, count_d;
  logic signed [9:0]         lower_q, lower_d;
  logic [9:0]                upper_q, upper_d;
  logic                      forced_q, forced_d;
  logic [8:0]                k_q, k_d;
  logic [BW-1:0]             kd_q, kd_d;
  logic                      rv_q, rv_d;
  logic [CW-1:0]             acc_q, acc_d;
  logic [LW-1:0]             lim_lo_q, lim_lo_d, lim_hi_q, lim_hi_d;
  logic [BW-1:0]             bin_q, bin_d;
  logic                      last_q, last_d;
  logic                      init_q, init_d;
  logic                      neg_q, neg_d;
  logic                      pk_q, pk_d;
  logic [7:0]                pm_q, pm_d;

  logic                      ov_q, ov_d;
  logic                      ok_q, ok_d;
  logic [7:0]                om_q, om_d;
  logic [8:0]                ol_q, ol_d, oh_q, oh_d;
  logic                      oz_q, oz_d;

  logic                      mem_we, mem_re;
  logic [BW-1:0]             mem_waddr, mem_raddr;
  logic [CW-1:0]             mem_wdata, mem_rdata;

  pcs_pkg::div_req_t         div_req;
  pcs_pkg::div_rsp_t         div_rsp;

  logic                      in_acc;
  logic [BW-1:0]             bin;
  logic signed [16:0]        diff;
  logic signed [24:0]        num;
  logic signed [10:0]        span;
  logic [8:0]                smag;
  logic [CW-1:0]             acc_n;
  logic [LW-1:0]             acc_sc;
  logic                      hit_lo, hit_hi;

  pcs_hist_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // APB: writes land on the access phase, reads are plain muxes
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pcs_pkg::REG_HIGH_PCT) ? 32'(high_pct_q) : 32'(low_pct_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_pct_q  <= pcs_pkg::PCT_RESET;
      high_pct_q <= pcs_pkg::PCT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == pcs_pkg::REG_LOW_PCT) begin
        low_pct_q <= pwdata[pcs_pkg::PCT_W-1:0];
      end else begin
        high_pct_q <= pwdata[pcs_pkg::PCT_W-1:0];
      end
    end
  end

  assign in_i.ready = (state_q == pcs_pkg::S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;

  // clamp the truncated integer part to a bin
  always_comb begin
    if (in_i.pixel[15]) begin
      bin = '0;
    end else if (in_i.pixel[14:12] != 3'd0) begin
      bin = '1;
    end else begin
      bin = in_i.pixel[11:4];
    end
  end

  // map numerator 255*(p - 16*low) and divisor 16*span, split into signs and magnitudes
  assign diff = $signed({in_i.pixel[15], in_i.pixel})
              - $signed({{3{lower_q[9]}}, lower_q, 4'b0000});
  assign num  = $signed({diff, 8'b0}) - $signed({{8{diff[16]}}, diff});
  always_comb begin
    span = $signed({1'b0, upper_q}) - $signed({lower_q[9], lower_q});
    if (span == 11'sd0) begin
      span = 11'sd1;
    end
    smag = span[10] ? 9'(-span) : span[8:0];
  end

  assign div_req.start   = in_acc && (in_i.cmd == pcs_pkg::CMD_MAP);
  assign div_req.num_mag = num[24] ? 24'(-num) : num[23:0];
  assign div_req.den_mag = {smag, 4'b0000};

  // walk compare: acc > floor(lim/1600) is acc*1600 > lim
  assign acc_n  = acc_q + mem_rdata;
  assign acc_sc = (LW'(acc_n) << 10) + (LW'(acc_n) << 9) + (LW'(acc_n) << 6);
  assign hit_lo = acc_sc > lim_lo_q;
  assign hit_hi = acc_sc > lim_hi_q;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    lower_d  = lower_q;
    upper_d  = upper_q;
    forced_d = forced_q;
    k_d      = k_q;
    kd_d     = kd_q;
    rv_d     = rv_q;
    acc_d    = acc_q;
    lim_lo_d = lim_lo_q;
    lim_hi_d = lim_hi_q;
    bin_d    = bin_q;
    last_d   = last_q;
    init_d   = init_q;
    neg_d    = neg_q;
    pk_d     = pk_q;
    pm_d     = pm_q;
    mem_we    = 1'b0;
    mem_waddr = k_q[BW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = k_q[BW-1:0];

    // drop the output beat once taken
    ov_d = ov_q && !out_o.ready;
    ok_d = ok_q;
    om_d = om_q;
    ol_d = ol_q;
    oh_d = oh_q;
    oz_d = oz_q;

    case (state_q)
      pcs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == pcs_pkg::CMD_MAP) begin
            neg_d   = num[24] ^ span[10];
            state_d = pcs_pkg::S_DIV;
          end else if (count_q < CW'(pcs_pkg::MAX_PIXELS)) begin
            mem_re    = 1'b1;
            mem_raddr = bin;
            bin_d     = bin;
            last_d    = in_i.last;
            state_d   = pcs_pkg::S_ACC_WR;
          end else if (in_i.last) begin
            state_d = pcs_pkg::S_MUL;
          end
        end
      end
      pcs_pkg::S_ACC_WR: begin
        mem_we    = 1'b1;
        mem_waddr = bin_q;
        mem_wdata = mem_rdata + CW'(1);
        count_d   = count_q + CW'(1);
        state_d   = last_q ? pcs_pkg::S_MUL : pcs_pkg::S_IDLE;
      end
      pcs_pkg::S_MUL: begin
        lim_lo_d = LW'(count_q) * LW'(low_pct_q);
        lim_hi_d = LW'(count_q) * LW'(high_pct_q);
        k_d      = '0;
        rv_d     = 1'b0;
        acc_d    = '0;
        state_d  = pcs_pkg::S_LOW;
      end
      pcs_pkg::S_LOW: begin
        // issue a read each cycle, judge the bin that returns
        mem_re = 1'b1;
        k_d    = k_q + 9'd1;
        kd_d   = k_q[BW-1:0];
        rv_d   = 1'b1;
        if (rv_q) begin
          acc_d = acc_n;
          if (hit_lo || kd_q == '1) begin
            lower_d = hit_lo ? $signed({2'b00, kd_q}) - 10'sd1 : 10'sd255;
            k_d     = 9'(pcs_pkg::BINS - 1);
            rv_d    = 1'b0;
            acc_d   = '0;
            state_d = pcs_pkg::S_HIGH;
          end
        end
      end
      pcs_pkg::S_HIGH: begin
        mem_re = 1'b1;
        k_d    = k_q - 9'd1;
        kd_d   = k_q[BW-1:0];
        rv_d   = 1'b1;
        if (rv_q) begin
          acc_d = acc_n;
          if (hit_hi || kd_q == BW'(1)) begin
            upper_d  = hit_hi ? {2'b00, kd_q} + 10'd1 : 10'd1;
            forced_d = (upper_d == lower_q);
            k_d      = '0;
            rv_d     = 1'b0;
            state_d  = pcs_pkg::S_CLEAR;
          end
        end
      end
      pcs_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        k_d    = k_q + 9'd1;
        if (k_q[BW-1:0] == '1) begin
          count_d = '0;
          if (init_q) begin
            init_d  = 1'b0;
            state_d = pcs_pkg::S_IDLE;
          end else begin
            pk_d    = pcs_pkg::KIND_LEVELS;
            pm_d    = '0;
            state_d = pcs_pkg::S_DONE;
          end
        end
      end
      pcs_pkg::S_DIV: begin
        if (div_rsp.done) begin
          pk_d    = pcs_pkg::KIND_PIXEL;
          pm_d    = neg_q ? 8'd0 : div_rsp.quot;
          state_d = pcs_pkg::S_DONE;
        end
      end
      pcs_pkg::S_DONE: begin
        // hold until the output register is free
        if (!ov_q || out_o.ready) begin
          ov_d    = 1'b1;
          ok_d    = pk_q;
          om_d    = pm_q;
          ol_d    = lower_q[8:0];
          oh_d    = upper_q[8:0];
          oz_d    = forced_q;
          state_d = pcs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pcs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pcs_pkg::S_CLEAR;
      init_q   <= 1'b1;
      k_q      <= '0;
      rv_q     <= 1'b0;
      count_q  <= '0;
      lower_q  <= 10'sd0;
      upper_q  <= 10'd255;
      forced_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      init_q   <= init_d;
      k_q      <= k_d;
      rv_q     <= rv_d;
      count_q  <= count_d;
      lower_q  <= lower_d;
      upper_q  <= upper_d;
      forced_q <= forced_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kd_q     <= kd_d;
    acc_q    <= acc_d;
    lim_lo_q <= lim_lo_d;
    lim_hi_q <= lim_hi_d;
    bin_q    <= bin_d;
    last_q   <= last_d;
    neg_q    <= neg_d;
    pk_q     <= pk_d;
    pm_q     <= pm_d;
    ok_q     <= ok_d;
    om_q     <= om_d;
    ol_q     <= ol_d;
    oh_q     <= oh_d;
    oz_q     <= oz_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.kind      = ok_q;
  assign out_o.mapped    = om_q;
  assign out_o.low_cut   = $signed(ol_q);
  assign out_o.high_cut  = oh_q;
  assign out_o.zero_span = oz_q;
endmodule
`default_nettype wire
